// ----- design/dhfk_pkg.sv -----
package dhfk_pkg;

    localparam int ROT_FRAC_DEF = 30;
    localparam int TRIG_ITER_DEF = 24;

    // cordic and multiplier operand width, raw product width, accumulator width
    localparam int CW = 34;
    localparam int PW = 2 * CW;
    localparam int AW = PW + 2;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic               joint_kind;
        logic signed [31:0] angle_offset;
        logic signed [31:0] axial_offset;
        logic signed [31:0] link_length;
        logic signed [31:0] link_twist;
        logic signed [31:0] joint_value;
        logic               last_joint;
    } joint_t;

    typedef struct packed {
        logic signed [31:0] r00;
        logic signed [31:0] r01;
        logic signed [31:0] r02;
        logic signed [31:0] r10;
        logic signed [31:0] r11;
        logic signed [31:0] r12;
        logic signed [31:0] r20;
        logic signed [31:0] r21;
        logic signed [31:0] r22;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } pose_t;

    localparam logic JOINT_REVOLUTE = 1'b0;

    // arctangent of 2^-i in binary-angle units
    function automatic logic signed [CW-1:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return CW'(v);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] hi;
        logic signed [AW-1:0] lo;
        hi = AW'(33'sd2147483647);
        lo = AW'(-33'sd2147483648);
        if (v > hi)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (v < lo)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// ----- design/dh_forward_kinematics_chain_unit.sv -----
// one cordic unit runs theta then alpha, one 34x34 multiplier then does 42 products
// input stalls while busy, so a new item is taken only once the last one is done
// a finished result waits in the output register while the next item is taken
// reset (rst_n low, async): pose is identity rotation, zero position, no result
module dh_forward_kinematics_chain_unit import dhfk_pkg::*; #(
    parameter int ROT_FRAC_BITS = ROT_FRAC_DEF,
    parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   joint_valid,
    output logic   joint_stall,
    input  joint_t joint,
    output logic   pose_valid,
    input  logic   pose_stall,
    output pose_t  pose
);

    localparam int IW = (TRIG_ITERATIONS > 1) ? $clog2(TRIG_ITERATIONS) : 1;
    localparam int CS = 30 - ROT_FRAC_BITS;
    localparam logic signed [CW-1:0] C_HALF =
        (CS == 0) ? '0 : (CW'(1) <<< ((CS > 0) ? CS - 1 : 0));
    localparam logic signed [PW-1:0] P_HALF = PW'(1) <<< (ROT_FRAC_BITS - 1);
    localparam logic signed [31:0] ONE = 32'(64'd1 << ROT_FRAC_BITS);
    localparam logic [IW-1:0] IT_LAST = IW'(TRIG_ITERATIONS - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CORDIC = 4'b0010,
        ST_MUL    = 4'b0100,
        ST_HOLD   = 4'b1000
    } state_t;

    typedef struct packed {
        logic       link;
        logic       neg;
        logic [2:0] lidx;
        logic [1:0] r;
        logic [1:0] k;
        logic [1:0] j;
    } tag_t;

    state_t state_reg;

    logic signed [31:0] alpha_reg;
    logic signed [31:0] d_reg;
    logic signed [31:0] a_reg;
    logic               last_reg;

    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic                 flip_reg;
    logic [IW-1:0]        it_reg;
    logic                 pass_reg;

    logic signed [CW-1:0] st_reg, ct_reg, sa_reg, ca_reg;
    logic signed [CW-1:0] link_reg [6];

    logic signed [31:0] rot_reg [3][3];
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] nrot_reg [3][3];
    logic signed [31:0] npos_reg [3];

    logic               link_phase_reg;
    logic [2:0]         lidx_reg;
    logic [1:0]         rr_reg, kk_reg, jj_reg;
    logic               issue_done_reg;
    logic signed [PW-1:0] prod_reg;
    logic               pv_reg;
    tag_t               tag_reg;
    logic signed [AW-1:0] acc_reg;

    logic   pose_valid_reg;
    pose_t  pose_reg;

    // input side
    logic        accept;
    logic [31:0] theta_in;
    logic signed [32:0] d_sum;
    logic signed [31:0] d_in;

    assign joint_stall = (state_reg != ST_IDLE);
    assign accept = joint_valid && !joint_stall;

    always_comb
    begin
        theta_in = joint.angle_offset;
        d_in = joint.axial_offset;
        d_sum = 33'(joint.axial_offset) + 33'(joint.joint_value);
        if (joint.joint_kind == JOINT_REVOLUTE)
        begin
            theta_in = joint.angle_offset + joint.joint_value;
        end
        else
        begin
            if (d_sum[32] != d_sum[31])
            begin
                d_in = d_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
            end
            else
            begin
                d_in = d_sum[31:0];
            end
        end
    end

    // cordic load: angles in the back half circle are turned by pi
    logic [31:0]          ld_ang;
    logic [31:0]          ld_quarter;
    logic                 ld_flip;
    logic signed [CW-1:0] ld_z;

    always_comb
    begin
        ld_ang = (state_reg == ST_IDLE) ? theta_in : alpha_reg;
        ld_quarter = ld_ang + 32'h40000000;
        ld_flip = ld_quarter[31];
        ld_z = CW'($signed(ld_flip ? (ld_ang ^ 32'h80000000) : ld_ang));
    end

    // one cordic rotation per cycle
    logic signed [CW-1:0] x_next, y_next, z_next, dx, dy, at;
    logic signed [CW-1:0] c_rnd, s_rnd, c_fin, s_fin;
    logic                 cordic_end;

    always_comb
    begin
        dx = y_reg >>> it_reg;
        dy = x_reg >>> it_reg;
        at = atan_entry(5'(it_reg));
        if (!z_reg[CW-1])
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - at;
        end
        else
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + at;
        end
        c_rnd = (x_next + C_HALF) >>> CS;
        s_rnd = (y_next + C_HALF) >>> CS;
        c_fin = flip_reg ? -c_rnd : c_rnd;
        s_fin = flip_reg ? -s_rnd : s_rnd;
        cordic_end = (it_reg == IT_LAST);
    end

    // link transform and multiplier operand select
    logic signed [CW-1:0] ar [3][3];
    logic signed [CW-1:0] ap [3];
    logic signed [CW-1:0] op_a, op_b;
    logic                 op_neg;

    always_comb
    begin
        ar[0][0] = ct_reg;
        ar[0][1] = link_reg[0];
        ar[0][2] = link_reg[1];
        ar[1][0] = st_reg;
        ar[1][1] = link_reg[2];
        ar[1][2] = link_reg[3];
        ar[2][0] = '0;
        ar[2][1] = sa_reg;
        ar[2][2] = ca_reg;
        ap[0] = link_reg[4];
        ap[1] = link_reg[5];
        ap[2] = CW'(d_reg);
        op_neg = 1'b0;
        if (link_phase_reg)
        begin
            case (lidx_reg)
                3'd0:
                begin
                    op_a = st_reg;
                    op_b = ca_reg;
                    op_neg = 1'b1;
                end
                3'd1:
                begin
                    op_a = st_reg;
                    op_b = sa_reg;
                end
                3'd2:
                begin
                    op_a = ct_reg;
                    op_b = ca_reg;
                end
                3'd3:
                begin
                    op_a = ct_reg;
                    op_b = sa_reg;
                    op_neg = 1'b1;
                end
                3'd4:
                begin
                    op_a = CW'(a_reg);
                    op_b = ct_reg;
                end
                default:
                begin
                    op_a = CW'(a_reg);
                    op_b = st_reg;
                end
            endcase
        end
        else
        begin
            op_a = CW'(rot_reg[rr_reg][jj_reg]);
            op_b = (kk_reg == 2'd3) ? ap[jj_reg] : ar[jj_reg][kk_reg];
        end
    end

    // drain side: round the registered product, accumulate
    logic signed [PW-1:0] rnd;
    logic signed [AW-1:0] base, sum;

    always_comb
    begin
        rnd = (prod_reg + P_HALF) >>> ROT_FRAC_BITS;
        base = (tag_reg.k == 2'd3) ? AW'(pos_reg[tag_reg.r]) : '0;
        sum = ((tag_reg.j == 2'd0) ? base : acc_reg) + AW'(rnd);
    end

    logic mul_done;
    logic finish_load;

    assign mul_done = issue_done_reg && !pv_reg;
    assign finish_load = ((state_reg == ST_MUL && mul_done) || state_reg == ST_HOLD)
                         && (!pose_valid_reg || !pose_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pass_reg <= 1'b0;
            it_reg <= '0;
            link_phase_reg <= 1'b0;
            lidx_reg <= '0;
            rr_reg <= '0;
            kk_reg <= '0;
            jj_reg <= '0;
            issue_done_reg <= 1'b0;
            pv_reg <= 1'b0;
            pose_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++)
            begin
                pos_reg[r] <= '0;
                for (int c = 0; c < 3; c++)
                begin
                    rot_reg[r][c] <= (r == c) ? ONE : '0;
                end
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_CORDIC;
                        pass_reg <= 1'b0;
                        it_reg <= '0;
                    end
                end
                ST_CORDIC:
                begin
                    if (cordic_end)
                    begin
                        it_reg <= '0;
                        if (pass_reg)
                        begin
                            state_reg <= ST_MUL;
                            link_phase_reg <= 1'b1;
                            lidx_reg <= '0;
                            rr_reg <= '0;
                            kk_reg <= '0;
                            jj_reg <= '0;
                            issue_done_reg <= 1'b0;
                            pv_reg <= 1'b0;
                        end
                        pass_reg <= 1'b1;
                    end
                    else
                    begin
                        it_reg <= it_reg + 1'b1;
                    end
                end
                ST_MUL:
                begin
                    pv_reg <= !issue_done_reg;
                    if (!issue_done_reg)
                    begin
                        if (link_phase_reg)
                        begin
                            if (lidx_reg == 3'd5)
                            begin
                                link_phase_reg <= 1'b0;
                            end
                            lidx_reg <= lidx_reg + 1'b1;
                        end
                        else if (jj_reg != 2'd2)
                        begin
                            jj_reg <= jj_reg + 1'b1;
                        end
                        else
                        begin
                            jj_reg <= '0;
                            if (kk_reg != 2'd3)
                            begin
                                kk_reg <= kk_reg + 1'b1;
                            end
                            else
                            begin
                                kk_reg <= '0;
                                if (rr_reg == 2'd2)
                                begin
                                    issue_done_reg <= 1'b1;
                                end
                                rr_reg <= rr_reg + 1'b1;
                            end
                        end
                    end
                    if (mul_done)
                    begin
                        if (finish_load)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_HOLD;
                        end
                    end
                end
                ST_HOLD:
                begin
                    if (finish_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (finish_load)
            begin
                pose_valid_reg <= 1'b1;
                for (int r = 0; r < 3; r++)
                begin
                    pos_reg[r] <= last_reg ? '0 : npos_reg[r];
                    for (int c = 0; c < 3; c++)
                    begin
                        rot_reg[r][c] <= last_reg ? ((r == c) ? ONE : '0) : nrot_reg[r][c];
                    end
                end
            end
            else if (pose_valid_reg && !pose_stall)
            begin
                pose_valid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            alpha_reg <= joint.link_twist;
            d_reg <= d_in;
            a_reg <= joint.link_length;
            last_reg <= joint.last_joint;
        end
        if (accept || (state_reg == ST_CORDIC && cordic_end && !pass_reg))
        begin
            x_reg <= CORDIC_GAIN;
            y_reg <= '0;
            z_reg <= ld_z;
            flip_reg <= ld_flip;
        end
        else if (state_reg == ST_CORDIC)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (state_reg == ST_CORDIC && cordic_end)
        begin
            if (pass_reg)
            begin
                ca_reg <= c_fin;
                sa_reg <= s_fin;
            end
            else
            begin
                ct_reg <= c_fin;
                st_reg <= s_fin;
            end
        end
        if (state_reg == ST_MUL && !issue_done_reg)
        begin
            prod_reg <= op_a * op_b;
            tag_reg.link <= link_phase_reg;
            tag_reg.neg <= op_neg;
            tag_reg.lidx <= lidx_reg;
            tag_reg.r <= rr_reg;
            tag_reg.k <= kk_reg;
            tag_reg.j <= jj_reg;
        end
        if (pv_reg)
        begin
            if (tag_reg.link)
            begin
                link_reg[tag_reg.lidx] <= tag_reg.neg ? -CW'(rnd) : CW'(rnd);
            end
            else
            begin
                acc_reg <= sum;
                if (tag_reg.j == 2'd2)
                begin
                    if (tag_reg.k == 2'd3)
                    begin
                        npos_reg[tag_reg.r] <= sat32(sum);
                    end
                    else
                    begin
                        nrot_reg[tag_reg.r][tag_reg.k] <= sat32(sum);
                    end
                end
            end
        end
        if (finish_load)
        begin
            pose_reg.r00 <= nrot_reg[0][0];
            pose_reg.r01 <= nrot_reg[0][1];
            pose_reg.r02 <= nrot_reg[0][2];
            pose_reg.r10 <= nrot_reg[1][0];
            pose_reg.r11 <= nrot_reg[1][1];
            pose_reg.r12 <= nrot_reg[1][2];
            pose_reg.r20 <= nrot_reg[2][0];
            pose_reg.r21 <= nrot_reg[2][1];
            pose_reg.r22 <= nrot_reg[2][2];
            pose_reg.pos_x <= npos_reg[0];
            pose_reg.pos_y <= npos_reg[1];
            pose_reg.pos_z <= npos_reg[2];
        end
    end

    assign pose_valid = pose_valid_reg;
    assign pose = pose_reg;

    a_accept_starts_cordic: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_CORDIC))
        else $error("accepted item did not start the cordic pass");

    a_last_clears_pose: assert property (@(posedge clk) disable iff (!rst_n)
        (finish_load && last_reg) |=>
            (rot_reg[0][0] == ONE && rot_reg[1][1] == ONE && rot_reg[0][1] == '0
             && pos_reg[0] == '0 && pos_reg[2] == '0))
        else $error("pose not back to identity after last joint");

    a_drain_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> (state_reg == ST_MUL))
        else $error("product drained outside the multiply phase");

endmodule

// ----- test/dh_forward_kinematics_chain_unit_tb.sv -----
`timescale 1ns / 1ps

module dh_forward_kinematics_chain_unit_tb import dhfk_pkg::*;;

    localparam int ROT_BITS = 30;
    localparam int CORDIC_STEPS = 24;
    localparam int LATENCY = 2 * CORDIC_STEPS + 44;

    class pose_scoreboard;
        longint rot[9];
        longint pos[3];
        pose_t expected_poses[$];
        int errors;
        longint atan_lut[32] = '{
            'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
            'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
            'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
            'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
            'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
            'h00000001, 'h00000000};

        function void home();
            for (int i = 0; i < 9; i++)
            begin
                rot[i] = (i % 4 == 0) ? (64'sd1 <<< ROT_BITS) : 0;
            end
            for (int i = 0; i < 3; i++)
            begin
                pos[i] = 0;
            end
        endfunction

        function longint round_shift(longint v, int s);
            if (s == 0)
            begin
                return v;
            end
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
            begin
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function longint qmul(longint a, longint b);
            return round_shift(a * b, ROT_BITS);
        endfunction

        function void sin_cos(logic [31:0] ang, output longint s, output longint c);
            bit flip;
            longint x, y, z, dx, dy;
            flip = 0;
            x = 652032874;
            y = 0;
            // fold the left half-plane onto the right one
            if (((ang + 32'h40000000) & 32'h80000000) != 0)
            begin
                ang = ang + 32'h80000000;
                flip = 1;
            end
            z = longint'($signed(ang));
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_lut[i];
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_lut[i];
                end
            end
            x = round_shift(x, 30 - ROT_BITS);
            y = round_shift(y, 30 - ROT_BITS);
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function void note_joint(joint_t j);
            logic [31:0] theta;
            longint d, st, ct, sa, ca, acc;
            longint link_rot[9], link_pos[3], nr[9], np[3];
            pose_t p;
            theta = j.angle_offset;
            d = longint'(j.axial_offset);
            if (j.joint_kind != JOINT_REVOLUTE)
            begin
                d = clamp32(d + longint'(j.joint_value));
            end
            else
            begin
                theta = theta + j.joint_value;
            end
            sin_cos(theta, st, ct);
            sin_cos(j.link_twist, sa, ca);
            link_rot[0] = ct;
            link_rot[1] = -qmul(st, ca);
            link_rot[2] = qmul(st, sa);
            link_rot[3] = st;
            link_rot[4] = qmul(ct, ca);
            link_rot[5] = -qmul(ct, sa);
            link_rot[6] = 0;
            link_rot[7] = sa;
            link_rot[8] = ca;
            link_pos[0] = qmul(longint'(j.link_length), ct);
            link_pos[1] = qmul(longint'(j.link_length), st);
            link_pos[2] = d;
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    acc = qmul(rot[r*3], link_rot[k]) + qmul(rot[r*3+1], link_rot[3+k])
                        + qmul(rot[r*3+2], link_rot[6+k]);
                    nr[r*3+k] = clamp32(acc);
                end
                acc = qmul(rot[r*3], link_pos[0]) + qmul(rot[r*3+1], link_pos[1])
                    + qmul(rot[r*3+2], link_pos[2]) + pos[r];
                np[r] = clamp32(acc);
            end
            for (int k = 0; k < 9; k++)
            begin
                rot[k] = nr[k];
                p[383 - 32*k -: 32] = nr[k][31:0];
            end
            for (int k = 0; k < 3; k++)
            begin
                pos[k] = np[k];
                p[95 - 32*k -: 32] = np[k][31:0];
            end
            expected_poses = {expected_poses, p};
            if (j.last_joint)
            begin
                home();
            end
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_pose(pose_t got);
            pose_t want;
            string names[12] = '{"r00", "r01", "r02", "r10", "r11", "r12",
                                 "r20", "r21", "r22", "pos_x", "pos_y", "pos_z"};
            if (expected_poses.size() == 0)
            begin
                report("pose with no joint pending");
                return;
            end
            want = expected_poses.pop_front();
            for (int i = 0; i < 12; i++)
            begin
                if (got[383 - 32*i -: 32] !== want[383 - 32*i -: 32])
                begin
                    report($sformatf("%s got %h want %h", names[i],
                        got[383 - 32*i -: 32], want[383 - 32*i -: 32]));
                end
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic joint_valid;
    logic joint_stall;
    joint_t joint;
    logic pose_valid;
    logic pose_stall;
    pose_t pose;

    pose_scoreboard sb;
    bit quiet;
    int stall_left;

    dh_forward_kinematics_chain_unit u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .joint_valid(joint_valid),
        .joint_stall(joint_stall),
        .joint(joint),
        .pose_valid(pose_valid),
        .pose_stall(pose_stall),
        .pose(pose)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        sb = new();
        sb.home();
        quiet = 0;
        stall_left = 0;
        rst_n = 1'b0;
        joint_valid = 1'b0;
        joint = '0;
        pose_stall = 1'b0;
    end

    // output side: check accepted poses, stall in short bursts
    always @(posedge clk)
    begin
        if (rst_n && pose_valid && !pose_stall)
        begin
            sb.check_pose(pose);
        end
        if (stall_left > 0)
        begin
            stall_left--;
            if (stall_left == 0)
            begin
                pose_stall <= 1'b0;
            end
        end
        else if (rst_n && !quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 3);
            pose_stall <= 1'b1;
        end
    end

    task automatic send_joint(joint_t j);
        int gap;
        joint <= j;
        joint_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (joint_stall);
        sb.note_joint(j);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            joint_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        joint_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_poses.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic joint_t make_joint(int k, int a, int d, int l, int t, int v, int e);
        joint_t j;
        j.joint_kind = k[0];
        j.angle_offset = a;
        j.axial_offset = d;
        j.link_length = l;
        j.link_twist = t;
        j.joint_value = v;
        j.last_joint = e[0];
        return j;
    endfunction

    function automatic logic [31:0] short_len();
        // within about +-16.0 in Q16.16
        return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endfunction

    initial
    begin
        joint_t j;
        int chain;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed joints
        send_joint(make_joint(0, 0, 0, 0, 0, 0, 0));
        send_joint(make_joint(0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
            32'h7FFFFFFF, 0));
        send_joint(make_joint(0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
            32'h80000000, 1));
        // revolute angle sums that wrap around the 32-bit angle
        send_joint(make_joint(0, 32'h70000000, 32'h00010000, 32'h00020000, 32'h40000000,
            32'h70000000, 0));
        send_joint(make_joint(0, 32'hC0000000, 0, 32'h00010000, 32'hC0000000, 32'h40000000, 1));
        // prismatic offset saturation both ways
        send_joint(make_joint(1, 0, 32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF, 0));
        send_joint(make_joint(1, 0, 32'h80000000, 0, 0, 32'h80000000, 1));
        // translation saturation along a straight chain
        for (int i = 0; i < 4; i++)
        begin
            send_joint(make_joint(1, 0, 32'h60000000, 32'h60000000, 0, 32'h10000000, 0));
        end
        for (int i = 0; i < 4; i++)
        begin
            send_joint(make_joint(0, 32'h80000000, 32'h90000000, 32'h90000000, 32'h20000000,
                32'h00000000, i == 3));
        end
        send_joint(make_joint(0, 32'hFFFFFFFF, 1, 32'hFFFFFFFF, 1, 32'hFFFFFFFF, 0));
        send_joint(make_joint(1, 32'h3FFFFFFF, 32'hFFFF0000, 32'h00010000, 32'hBFFFFFFF,
            32'h00008000, 1));
        settle();

        // random chains, with some noise items
        for (int n = 0; n < 600; n += chain)
        begin
            chain = $urandom_range(1, 7);
            if (n > 540)
            begin
                quiet = 1;
            end
            if (n > 250 && n < 262)
            begin
                settle();
            end
            for (int i = 0; i < chain; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    j.joint_kind = 1'($urandom);
                    j.angle_offset = $urandom;
                    j.axial_offset = $urandom;
                    j.link_length = $urandom;
                    j.link_twist = $urandom;
                    j.joint_value = $urandom;
                    j.last_joint = 1'($urandom);
                end
                else
                begin
                    j.joint_kind = 1'($urandom_range(0, 1));
                    j.angle_offset = $urandom;
                    j.axial_offset = short_len();
                    j.link_length = short_len();
                    j.link_twist = $urandom;
                    j.joint_value = j.joint_kind ? short_len() : $urandom;
                    j.last_joint = (i == chain - 1);
                end
                send_joint(j);
            end
        end
        settle();
        repeat (LATENCY + 20) @(posedge clk);
        if (sb.errors == 0 && sb.expected_poses.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/dhfk_pkg.sv
design/dh_forward_kinematics_chain_unit.sv
test/dh_forward_kinematics_chain_unit_tb.sv
